### rtl/core/tsq_pkg.sv
`default_nettype none

package tsq_pkg;

  // Default sizing of the two stacks.
  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port widths.
  localparam int VALUE_W  = 32;
  localparam int CAP_W    = 6;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // Operation codes carried on the mode field.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFER,
    ST_XFER_LAST,
    ST_POP_RD,
    ST_EMIT
  } state_t;

  // Conditions seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic pop;
    logic full;
    logic in_empty;
    logic out_empty;
    logic rd_zero;
    logic out_free;
  } tsq_sts_t;

  // Strobes issued by the sequencer.
  typedef struct packed {
    logic idle;
    logic push_ok;
    logic push_full;
    logic pop_hit;
    logic pop_empty;
    logic xfer_start;
    logic xfer_step;
    logic xfer_last;
    logic pop_rd;
    logic emit;
  } tsq_ctl_t;

endpackage

`default_nettype wire

### rtl/core/tsq_ctrl.sv
`default_nettype none

module tsq_ctrl import tsq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tsq_sts_t sts,
  output tsq_ctl_t      ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) begin
          if (sts.pop && sts.out_empty && !sts.in_empty) begin
            state_nxt = ST_XFER;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_XFER: begin
        if (sts.rd_zero) begin
          state_nxt = ST_XFER_LAST;
        end
      end
      ST_XFER_LAST: state_nxt = ST_POP_RD;
      ST_POP_RD:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.idle = 1'b1;
        if (sts.in_valid) begin
          if (!sts.pop) begin
            ctl.push_ok   = !sts.full;
            ctl.push_full = sts.full;
          end else if (!sts.out_empty) begin
            ctl.pop_hit = 1'b1;
          end else if (sts.in_empty) begin
            ctl.pop_empty = 1'b1;
          end else begin
            ctl.xfer_start = 1'b1;
          end
        end
      end
      ST_XFER:      ctl.xfer_step = 1'b1;
      ST_XFER_LAST: ctl.xfer_last = 1'b1;
      ST_POP_RD:    ctl.pop_rd    = 1'b1;
      ST_EMIT:      ctl.emit      = sts.out_free;
      default:      ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/two_stack_fifo_queue.sv
`default_nettype none

// First-in first-out queue built from an input stack and an output stack.
// Each transaction on the in_ channel is a push (in_mode low, in_value
// stored) or a pop (in_mode high). Every transaction gives exactly one
// result on the out_ channel: out_status (ok, full or empty) and
// out_value_out, the popped word on a successful pop and zero otherwise.
// cfg_capacity sets how many entries the input stack may hold; it is
// always ready and should be written only while the queue is idle.
// A push, or a pop that finds the output stack non-empty, goes through
// the result registers to the output register; in_stall stays high until
// the result is emitted. A pop that finds the output stack empty first
// copies all n input-stack entries, one per cycle through the memory read
// port, and then pops the oldest. Each word is copied once.
// Reset empties both stacks and sets the capacity to 32; the stack memories
// themselves are not cleared. The output register holds a result until it
// is taken: while out_stall is high one further transaction is accepted and
// its result waits inside until the output register frees.
module two_stack_fifo_queue import tsq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_mode,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic             [STATUS_W-1:0] out_status,
  output logic signed      [VALUE_W-1:0]  out_value_out,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic        [CAP_W-1:0]    cfg_capacity
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  tsq_sts_t sts;
  tsq_ctl_t ctl;

  logic [CAP_W-1:0]      cap_r;
  logic [CNT_W-1:0]      in_count_r;
  logic [CNT_W-1:0]      in_count_nxt;
  logic [CNT_W-1:0]      out_count_r;
  logic [CNT_W-1:0]      out_count_nxt;
  logic [AW-1:0]         rd_addr_r;
  logic [AW-1:0]         rd_addr_nxt;
  logic [AW-1:0]         wr_addr_r;
  logic [AW-1:0]         wr_addr_nxt;
  logic                  wr_pend_r;
  logic                  wr_pend_nxt;
  status_t               res_status_r;
  status_t               res_status_nxt;
  logic                  res_mem_r;
  logic                  res_mem_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  status_t               out_status_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic [VALUE_W-1:0]    out_value_nxt;

  logic [DATA_WIDTH-1:0] in_stack_mem  [DEPTH];
  logic [DATA_WIDTH-1:0] out_stack_mem [DEPTH];
  logic [DATA_WIDTH-1:0] in_rdata_r;
  logic [DATA_WIDTH-1:0] out_rdata_r;
  logic [63:0]           push_wide;
  logic [63:0]           pop_wide;
  logic                  in_we;
  logic                  out_we;
  logic                  out_re;
  logic [AW-1:0]         out_raddr;
  logic                  full;

  // The stack saturates at DEPTH entries whatever the capacity says.
  assign full = (CMP_W'(in_count_r) >= CMP_W'(cap_r)) ||
                (in_count_r == CNT_W'(DEPTH));

  assign sts.in_valid  = in_valid;
  assign sts.pop       = (in_mode == MODE_POP);
  assign sts.full      = full;
  assign sts.in_empty  = (in_count_r == '0);
  assign sts.out_empty = (out_count_r == '0);
  assign sts.rd_zero   = (rd_addr_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  tsq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  assign in_stall  = !ctl.idle;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity;
    end
  end

  // Stack memories: one write and one registered read each.
  assign push_wide = 64'($unsigned(in_value));
  assign in_we     = ctl.push_ok;
  assign out_we    = ctl.xfer_last || (ctl.xfer_step && wr_pend_r);
  assign out_re    = ctl.pop_hit || ctl.pop_rd;
  assign out_raddr = ctl.pop_rd ? wr_addr_r : AW'(out_count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_stack_mem[AW'(in_count_r)] <= push_wide[DATA_WIDTH-1:0];
    end
    in_rdata_r <= in_stack_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_stack_mem[wr_addr_r] <= in_rdata_r;
    end
    if (out_re) begin
      out_rdata_r <= out_stack_mem[out_raddr];
    end
  end

  always_comb begin
    in_count_nxt   = in_count_r;
    out_count_nxt  = out_count_r;
    rd_addr_nxt    = rd_addr_r;
    wr_addr_nxt    = wr_addr_r;
    wr_pend_nxt    = wr_pend_r;
    res_status_nxt = res_status_r;
    res_mem_nxt    = res_mem_r;

    if (ctl.push_ok) begin
      in_count_nxt   = in_count_r + CNT_W'(1);
      res_status_nxt = STATUS_OK;
      res_mem_nxt    = 1'b0;
    end
    if (ctl.push_full) begin
      res_status_nxt = STATUS_FULL;
      res_mem_nxt    = 1'b0;
    end
    if (ctl.pop_empty) begin
      res_status_nxt = STATUS_EMPTY;
      res_mem_nxt    = 1'b0;
    end
    if (ctl.pop_hit) begin
      out_count_nxt  = out_count_r - CNT_W'(1);
      res_status_nxt = STATUS_OK;
      res_mem_nxt    = 1'b1;
    end
    // The copy reads the input stack from the top down and writes the
    // output stack from the bottom up, each word in the cycle after its read.
    if (ctl.xfer_start) begin
      rd_addr_nxt  = AW'(in_count_r - CNT_W'(1));
      wr_addr_nxt  = '0;
      wr_pend_nxt  = 1'b0;
      in_count_nxt = '0;
    end
    if (ctl.xfer_step) begin
      wr_pend_nxt = 1'b1;
      if (!sts.rd_zero) begin
        rd_addr_nxt = rd_addr_r - AW'(1);
      end
      if (wr_pend_r) begin
        wr_addr_nxt = wr_addr_r + AW'(1);
      end
    end
    // The last word written is the oldest; it is popped straight away.
    if (ctl.pop_rd) begin
      out_count_nxt  = CNT_W'(wr_addr_r);
      res_status_nxt = STATUS_OK;
      res_mem_nxt    = 1'b1;
    end
  end

  assign pop_wide = 64'(out_rdata_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res_mem_r ? pop_wide[VALUE_W-1:0] : '0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= '0;
      out_count_r <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_count_r  <= in_count_nxt;
      out_count_r <= out_count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    res_status_r <= res_status_nxt;
    res_mem_r    <= res_mem_nxt;
    out_value_r  <= out_value_nxt;
    if (ctl.emit) begin
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

  // A rejected push leaves the input stack untouched.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push_full |=> $stable(in_count_r))
    else $error("input stack count changed on a full push");

  // While the copy runs, both counts are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.xfer_step |-> (in_count_r == '0) && (out_count_r == '0))
    else $error("stack count not zero during copy");

  // A pop served from the output stack takes exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop_hit |=> out_count_r == $past(out_count_r) - CNT_W'(1))
    else $error("output stack count not decremented on pop");

  // Empty is only reported when both stacks really are empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit && (res_status_r == STATUS_EMPTY) |->
      (in_count_r == '0) && (out_count_r == '0))
    else $error("empty reported with entries held");

endmodule

`default_nettype wire

### tb/two_stack_fifo_queue_tb.sv
`default_nettype none

module two_stack_fifo_queue_tb;
  import tsq_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int IDLE_LIMIT  = 5000;

  typedef struct {
    status_t            status;
    logic [VALUE_W-1:0] word;
  } queue_result_t;

  // Mirrors both stacks and the capacity register, and keeps the results
  // that accepted transactions are owed, oldest first.
  class queue_scoreboard;
    logic [VALUE_W-1:0] input_stack[STACK_DEPTH];
    logic [VALUE_W-1:0] output_stack[STACK_DEPTH];
    int unsigned        input_count;
    int unsigned        output_count;
    int unsigned        capacity;
    queue_result_t      owed_results[$];
    int                 fail_count;

    function new();
      input_count  = 0;
      output_count = 0;
      capacity     = CAP_RESET;
      fail_count   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void note_transaction(logic mode, logic [VALUE_W-1:0] value);
      queue_result_t res;
      int unsigned   limit;
      int unsigned   n;
      res.status = STATUS_OK;
      res.word   = '0;
      limit = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
      if (mode == MODE_PUSH) begin
        if (input_count >= limit) begin
          res.status = STATUS_FULL;
        end else begin
          input_stack[input_count] = value;
          input_count++;
        end
      end else begin
        // Refill reverses the input stack so that the oldest word ends on top.
        if (output_count == 0 && input_count != 0) begin
          n = input_count;
          for (int i = 0; i < n; i++) output_stack[i] = input_stack[n - 1 - i];
          output_count = n;
          input_count  = 0;
        end
        if (output_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          output_count--;
          res.word = output_stack[output_count];
        end
      end
      owed_results.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] word);
      queue_result_t res;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d value %h", $time, status, word);
        fail_count++;
        return;
      end
      res = owed_results.pop_front();
      if (status !== res.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, res.status, status);
        fail_count++;
      end
      if (word !== res.word) begin
        $display("%0t: value mismatch: expected %h actual %h", $time, res.word, word);
        fail_count++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_mode = MODE_PUSH;
  logic signed [VALUE_W-1:0]  in_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [STATUS_W-1:0] out_status;
  logic signed [VALUE_W-1:0]  out_value_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic        [CAP_W-1:0]    cfg_capacity = '0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  queue_scoreboard sb = new();

  two_stack_fifo_queue dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_value_out(out_value_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_capacity);
      if (in_valid && !in_stall) sb.note_transaction(in_mode, in_value);
      if (out_valid && !out_stall) sb.check_result(out_status, out_value_out);
    end
  end

  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_op(input logic mode, input logic [VALUE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // The capacity is only changed once every owed result has been taken.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 31))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_segment(input logic [CAP_W-1:0] cap, input int count, input int push_pct);
    write_capacity(cap);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < push_pct) send_op(MODE_PUSH, pick_word());
      else send_op(MODE_POP, $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] seg_caps[16];
    int               push_mix[4];
    int               phase_idle[4];
    int               phase_stall[4];
    seg_caps    = '{6'd63, 6'd1, 6'd32, 6'd0, 6'd8, 6'd2, 6'd33, 6'd17,
                    6'd4, 6'd63, 6'd1, 6'd32, 6'd3, 6'd16, 6'd0, 6'd47};
    push_mix    = '{75, 60, 40, 25};
    phase_idle  = '{0, 56, 0, 27};
    phase_stall = '{0, 0, 56, 27};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, value extremes, full with room left in the output
    // stack, refill order, zero capacity, and a capacity lowered below the fill.
    send_op(MODE_POP, 32'hDEAD_BEEF);
    write_capacity(6'd2);
    send_op(MODE_PUSH, 32'h7FFF_FFFF);
    send_op(MODE_PUSH, 32'h8000_0000);
    send_op(MODE_PUSH, 32'h1111_1111);
    send_op(MODE_POP, 32'h0);
    send_op(MODE_PUSH, 32'hFFFF_FFFF);
    send_op(MODE_PUSH, 32'h0000_0000);
    send_op(MODE_PUSH, 32'h2222_2222);
    send_op(MODE_POP, 32'hFFFF_FFFF);
    send_op(MODE_POP, 32'h0);
    send_op(MODE_POP, 32'h0);
    send_op(MODE_POP, 32'h0);
    write_capacity(6'd0);
    send_op(MODE_PUSH, 32'h3333_3333);
    send_op(MODE_POP, 32'h0);
    write_capacity(6'd32);
    send_op(MODE_PUSH, 32'h5555_5555);
    send_op(MODE_PUSH, 32'hAAAA_AAAA);
    send_op(MODE_PUSH, 32'h0000_0001);
    send_op(MODE_PUSH, 32'h1234_5678);
    write_capacity(6'd3);
    send_op(MODE_PUSH, 32'h4444_4444);
    send_op(MODE_POP, 32'h0);
    send_op(MODE_PUSH, 32'h6666_6666);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int s = 0; s < 4; s++) begin
        run_segment(seg_caps[p * 4 + s], 50, push_mix[s]);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
